// ----- src/mi3_pkg.sv -----
// shared constants for the 3x3 matrix inverse core
package mi3_pkg;

    localparam int NUM_ELEM = 9;
    localparam int NUM_PROD = 18;

    // product operand pairs; cofactor k is prod(2k) - prod(2k+1), signs folded in
    localparam int PROD_A [0:NUM_PROD-1] = '{4, 5, 5, 3, 3, 4, 2, 1, 0,
                                             2, 1, 0, 1, 2, 2, 0, 0, 1};
    localparam int PROD_B [0:NUM_PROD-1] = '{8, 7, 6, 8, 7, 6, 7, 8, 8,
                                             6, 6, 7, 5, 4, 3, 5, 4, 3};

endpackage

// ----- src/matrix3_inverse_core.sv -----
// 3x3 fixed-point matrix inverse core, top level
// throughput: one matrix per cycle while no stage is stalled; the division unit retires one quotient bit per stage
// front and back pipelines stall independently behind a four-entry queue
// reset: synchronous active-low aresetn clears all valid flags and queue pointers
// datapath registers are not reset
module matrix3_inverse_core #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ELEM_WIDTH-1:0] s_m_00,
    input  logic [ELEM_WIDTH-1:0] s_m_01,
    input  logic [ELEM_WIDTH-1:0] s_m_02,
    input  logic [ELEM_WIDTH-1:0] s_m_10,
    input  logic [ELEM_WIDTH-1:0] s_m_11,
    input  logic [ELEM_WIDTH-1:0] s_m_12,
    input  logic [ELEM_WIDTH-1:0] s_m_20,
    input  logic [ELEM_WIDTH-1:0] s_m_21,
    input  logic [ELEM_WIDTH-1:0] s_m_22,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ELEM_WIDTH-1:0] m_inv_00,
    output logic [ELEM_WIDTH-1:0] m_inv_01,
    output logic [ELEM_WIDTH-1:0] m_inv_02,
    output logic [ELEM_WIDTH-1:0] m_inv_10,
    output logic [ELEM_WIDTH-1:0] m_inv_11,
    output logic [ELEM_WIDTH-1:0] m_inv_12,
    output logic [ELEM_WIDTH-1:0] m_inv_20,
    output logic [ELEM_WIDTH-1:0] m_inv_21,
    output logic [ELEM_WIDTH-1:0] m_inv_22,
    output logic                  m_singular,
    output logic                  m_saturated
);

    localparam int NE = mi3_pkg::NUM_ELEM;
    localparam int W  = ELEM_WIDTH;
    localparam int EW = NE * (2 * W + 1) + 3 * W + 2;

    logic [NE*W-1:0] mat;
    logic [NE*W-1:0] inv;
    logic [EW-1:0]   fq_data, qb_data;
    logic            fq_valid, fq_ready;
    logic            qb_valid, qb_ready;

    assign mat = {s_m_22, s_m_21, s_m_20, s_m_12, s_m_11, s_m_10, s_m_02, s_m_01, s_m_00};

    mi3_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_mat    (mat),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_data  (fq_data)
    );

    mi3_queue #(.EW(EW)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    mi3_back #(.W(W), .F(FRAC_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_data       (qb_data),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_inv       (inv),
        .out_singular  (m_singular),
        .out_saturated (m_saturated)
    );

    // lanes carry cofactors in row order; the adjugate is their transpose
    assign m_inv_00 = inv[0*W +: W];
    assign m_inv_01 = inv[3*W +: W];
    assign m_inv_02 = inv[6*W +: W];
    assign m_inv_10 = inv[1*W +: W];
    assign m_inv_11 = inv[4*W +: W];
    assign m_inv_12 = inv[7*W +: W];
    assign m_inv_20 = inv[2*W +: W];
    assign m_inv_21 = inv[5*W +: W];
    assign m_inv_22 = inv[8*W +: W];

`ifndef SYNTH
    a_sing_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> !m_saturated)
        else $error("singular beat flagged saturated");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> (inv == '0))
        else $error("singular beat with nonzero elements");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");
`endif

endmodule

// ----- src/mi3_front.sv -----
// front pipeline: cofactors, determinant and singular detection
module mi3_front #(
    parameter int W = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [mi3_pkg::NUM_ELEM*W-1:0]          in_mat,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mi3_pkg::NUM_ELEM*(2*W+1)+3*W+1:0] out_data
);

    localparam int NE  = mi3_pkg::NUM_ELEM;
    localparam int NP  = mi3_pkg::NUM_PROD;
    localparam int PW  = 2 * W;
    localparam int CW  = 2 * W + 1;
    localparam int XW  = 2 * W + 1;
    localparam int TW  = 3 * W + 1;
    localparam int DW  = 3 * W + 2;
    localparam int DMW = 3 * W;
    localparam int LAT = 6;

    logic [LAT-1:0] vld_reg, vld_next;
    logic           en;

    logic signed [W-1:0]   e [NE];
    logic signed [PW-1:0]  prod_reg [NP];
    logic signed [W-1:0]   r1_reg [3];
    logic signed [W-1:0]   r2_reg [3];
    logic signed [CW-1:0]  cof_reg [NE];
    logic signed [XW-1:0]  pl_reg [3];
    logic signed [XW-1:0]  ph_reg [3];
    logic signed [TW-1:0]  term_reg [3];
    logic signed [DW-1:0]  det_reg;
    logic [PW-1:0]         cm3_reg [NE];
    logic [PW-1:0]         cm4_reg [NE];
    logic [PW-1:0]         cm5_reg [NE];
    logic [PW-1:0]         cm6_reg [NE];
    logic [NE-1:0]         cs3_reg, cs4_reg, cs5_reg, cs6_reg;
    logic [DMW-1:0]        dmag_reg;
    logic                  dsgn_reg;
    logic                  sing_reg;

    assign en       = !(vld_reg[LAT-1] && !out_ready);
    assign in_ready = en;
    assign out_valid = vld_reg[LAT-1];

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            e[i] = signed'(in_mat[i*W +: W]);
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // products
            for (int j = 0; j < NP; j++) begin
                prod_reg[j] <= PW'(e[mi3_pkg::PROD_A[j]]) * PW'(e[mi3_pkg::PROD_B[j]]);
            end
            for (int i = 0; i < 3; i++) begin
                r1_reg[i] <= e[i];
                r2_reg[i] <= r1_reg[i];
            end
            // cofactors
            for (int k = 0; k < NE; k++) begin
                cof_reg[k] <= CW'(prod_reg[2*k]) - CW'(prod_reg[2*k+1]);
            end
            // determinant partial products and cofactor magnitudes
            for (int i = 0; i < 3; i++) begin
                pl_reg[i] <= XW'(r2_reg[i]) * XW'(signed'({1'b0, cof_reg[i][W-1:0]}));
                ph_reg[i] <= XW'(r2_reg[i]) * XW'(signed'(cof_reg[i][CW-1:W]));
            end
            for (int k = 0; k < NE; k++) begin
                cm3_reg[k] <= PW'(cof_reg[k][CW-1] ? -cof_reg[k] : cof_reg[k]);
                cs3_reg[k] <= cof_reg[k][CW-1];
            end
            for (int i = 0; i < 3; i++) begin
                term_reg[i] <= (TW'(ph_reg[i]) <<< W) + TW'(pl_reg[i]);
            end
            cm4_reg <= cm3_reg;
            cs4_reg <= cs3_reg;
            det_reg <= DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
            cm5_reg <= cm4_reg;
            cs5_reg <= cs4_reg;
            dmag_reg <= DMW'(det_reg[DW-1] ? -det_reg : det_reg);
            dsgn_reg <= det_reg[DW-1];
            sing_reg <= (det_reg == '0);
            cm6_reg  <= cm5_reg;
            cs6_reg  <= cs5_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            out_data[k*PW +: PW] = cm6_reg[k];
        end
        out_data[NE*PW +: NE]       = cs6_reg;
        out_data[NE*PW+NE +: DMW]   = dmag_reg;
        out_data[NE*PW+NE+DMW]      = dsgn_reg;
        out_data[NE*PW+NE+DMW+1]    = sing_reg;
    end

endmodule

// ----- src/mi3_queue.sv -----
// short fifo between the front and back pipelines
module mi3_queue #(
    parameter int EW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [EW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [EW-1:0] pop_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [EW-1:0]   mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            push, pop;

    assign push_ready = (cnt_reg != CNTW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + AW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + AW'(1) : rd_reg;
        cnt_next = cnt_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ----- src/mi3_back.sv -----
// back pipeline: bit-per-stage division, rounding and saturation
module mi3_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [mi3_pkg::NUM_ELEM*(2*W+1)+3*W+1:0] in_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mi3_pkg::NUM_ELEM*W-1:0]          out_inv,
    output logic                                    out_singular,
    output logic                                    out_saturated
);

    localparam int NE  = mi3_pkg::NUM_ELEM;
    localparam int PW  = 2 * W;
    localparam int DMW = 3 * W;
    localparam int NW  = 2 * W + 2 * F;
    localparam int RW  = (NW > 4 * W) ? NW : 4 * W;
    localparam int NS  = W + 3;

    logic [NS-1:0] vld_reg, vld_next;
    logic          en;

    logic [RW-1:0]  num [NE];
    logic [NE-1:0]  ovf0;
    logic [NE-1:0]  neg0;

    logic [RW-1:0]  rem_reg [W+1][NE];
    logic [W-1:0]   q_reg [W+1][NE];
    logic [NE-1:0]  neg_reg [W+1];
    logic [NE-1:0]  ovf_reg [W+1];
    logic [DMW-1:0] dm_reg [W+1];
    logic           sg_reg [W+1];

    logic [RW-1:0]  dsh [W];
    logic           ge [W][NE];

    logic [W:0]     qr_reg [NE];
    logic [NE-1:0]  rneg_reg, rovf_reg;
    logic           rsg_reg;
    logic [NE-1:0]  rup;

    logic [W:0]     lim [NE];
    logic [W:0]     qv [NE];
    logic [W:0]     sv [NE];
    logic [NE-1:0]  clip;

    logic [W-1:0]   inv_reg [NE];
    logic           sing_out_reg;
    logic           sat_out_reg;

    assign en        = !(vld_reg[NS-1] && !out_ready);
    assign in_ready  = en;
    assign out_valid = vld_reg[NS-1];

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // numerator scaling and quotient range check
    always_comb begin
        for (int i = 0; i < NE; i++) begin
            num[i]  = RW'(in_data[i*PW +: PW]) << (2 * F);
            ovf0[i] = num[i] >= (RW'(in_data[NE*PW+NE +: DMW]) << W);
            neg0[i] = in_data[NE*PW + i] ^ in_data[NE*PW+NE+DMW];
        end
    end

    always_comb begin
        for (int s = 0; s < W; s++) begin
            dsh[s] = RW'(dm_reg[s]) << (W - 1 - s);
            for (int i = 0; i < NE; i++) begin
                ge[s][i] = rem_reg[s][i] >= dsh[s];
            end
        end
        for (int i = 0; i < NE; i++) begin
            rup[i] = ((RW+1)'(rem_reg[W][i]) << 1) >= (RW+1)'(dm_reg[W]);
        end
    end

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            lim[i]  = rneg_reg[i] ? ((W+1)'(1) << (W - 1))
                                  : ((W+1)'(1) << (W - 1)) - (W+1)'(1);
            clip[i] = rovf_reg[i] || (qr_reg[i] > lim[i]);
            qv[i]   = clip[i] ? lim[i] : qr_reg[i];
            sv[i]   = rneg_reg[i] ? -qv[i] : qv[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NE; i++) begin
                rem_reg[0][i] <= num[i];
                q_reg[0][i]   <= '0;
            end
            neg_reg[0] <= neg0;
            ovf_reg[0] <= ovf0;
            dm_reg[0]  <= in_data[NE*PW+NE +: DMW];
            sg_reg[0]  <= in_data[NE*PW+NE+DMW+1];
            // one quotient bit per stage
            for (int s = 0; s < W; s++) begin
                for (int i = 0; i < NE; i++) begin
                    rem_reg[s+1][i] <= ge[s][i] ? rem_reg[s][i] - dsh[s] : rem_reg[s][i];
                    q_reg[s+1][i]   <= {q_reg[s][i][W-2:0], ge[s][i]};
                end
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                dm_reg[s+1]  <= dm_reg[s];
                sg_reg[s+1]  <= sg_reg[s];
            end
            // round half away from zero
            for (int i = 0; i < NE; i++) begin
                qr_reg[i] <= {1'b0, q_reg[W][i]} + (W+1)'(rup[i]);
            end
            rneg_reg <= neg_reg[W];
            rovf_reg <= ovf_reg[W];
            rsg_reg  <= sg_reg[W];
            // saturate and apply sign, or force zero for a singular matrix
            for (int i = 0; i < NE; i++) begin
                inv_reg[i] <= rsg_reg ? '0 : sv[i][W-1:0];
            end
            sing_out_reg <= rsg_reg;
            sat_out_reg  <= !rsg_reg && (clip != '0);
        end
    end

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            out_inv[i*W +: W] = inv_reg[i];
        end
    end

    assign out_singular  = sing_out_reg;
    assign out_saturated = sat_out_reg;

endmodule
